// ----- rtl/rcs_pkg.sv -----
// Package for rgb_channel_statistics: widths, constants and sequencer state type.
// No dependencies.
package rcs_pkg;

	localparam int MaxWidth  = 4096;
	localparam int MaxHeight = 4096;
	localparam int DimW      = 13;
	localparam int PixW      = 8;
	localparam int SumW      = 32;
	localparam int SqW       = 40;
	localparam int CntW      = 24;
	localparam int NW        = 25;
	localparam int MeanW     = 16;
	localparam int DevW      = 15;
	localparam int NumW      = 66;
	localparam int DivW      = 50;
	localparam int DivSteps  = 50;

	localparam logic [0:0] RegWidth  = 1'b0;
	localparam logic [0:0] RegHeight = 1'b1;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_NMUL,
		ST_CHAN,
		ST_MEAN,
		ST_SQA,
		ST_SQH,
		ST_SQB,
		ST_DIFF,
		ST_VDIV,
		ST_SQRT,
		ST_NEXT,
		ST_OUT
	} seq_state_t;

endpackage

// ----- rtl/rgb_channel_statistics.sv -----
// Top level of rgb_channel_statistics: per-channel sum, sum of squares, min and max
// of an RGB frame, with mean and deviation worked out by a shared iterative unit.
// Depends on rcs_pkg.
//
// Usage: pixels enter on the in channel (in_valid/in_ready, red/green/blue).
// Configuration writes (cfg_valid/cfg_ready, cfg_index, cfg_data) set frame_width
// (index 0) and frame_height (index 1); zero reads as 1, above 4096 as 4096.
// A pixel that does not end a frame updates its accumulators on the accept
// edge, and in_ready stays high.
// The pixel that ends a frame starts the end-of-frame sequence: one multiply for
// N, then per channel a 50-step restoring divide for the mean, multiplies and a
// subtract for the variance numerator, a second 50-step divide by N^2, and a
// 16-step square root. From the accept of the last pixel to out_valid, in_ready
// is low.
// All of it runs on one shared shift/subtract datapath.
// The result then sits in the output register with out_valid high until taken;
// a stalled receiver holds the block, and no pixel is accepted meanwhile.
// Reset sets the registers to 1920 x 1080, clears the accumulators, and leaves
// no result pending.
module rgb_channel_statistics (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_valid,
	output logic                      cfg_ready,
	input  logic [0:0]                cfg_index,
	input  logic [rcs_pkg::DimW-1:0]  cfg_data,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  logic [rcs_pkg::PixW-1:0]  red,
	input  logic [rcs_pkg::PixW-1:0]  green,
	input  logic [rcs_pkg::PixW-1:0]  blue,
	output logic                      out_valid,
	input  logic                      out_ready,
	output logic [rcs_pkg::MeanW-1:0] mean_red,
	output logic [rcs_pkg::MeanW-1:0] mean_green,
	output logic [rcs_pkg::MeanW-1:0] mean_blue,
	output logic [rcs_pkg::DevW-1:0]  dev_red,
	output logic [rcs_pkg::DevW-1:0]  dev_green,
	output logic [rcs_pkg::DevW-1:0]  dev_blue,
	output logic [rcs_pkg::PixW-1:0]  min_red,
	output logic [rcs_pkg::PixW-1:0]  min_green,
	output logic [rcs_pkg::PixW-1:0]  min_blue,
	output logic [rcs_pkg::PixW-1:0]  max_red,
	output logic [rcs_pkg::PixW-1:0]  max_green,
	output logic [rcs_pkg::PixW-1:0]  max_blue
);
	import rcs_pkg::*;

	// configuration registers
	logic [DimW-1:0] width_q, height_q;
	logic [DimW-1:0] w_eff, h_eff;
	logic [NW-1:0]   n_full;
	logic            in_acc, last_pix;

	// accumulators
	logic [SumW-1:0] sum_q [3];
	logic [SqW-1:0]  sq_q  [3];
	logic [PixW-1:0] min_q [3];
	logic [PixW-1:0] max_q [3];
	logic [CntW-1:0] cnt_q;
	logic [PixW-1:0] pix   [3];

	// frame snapshot for the sequencer
	logic [SumW-1:0] fsum_q [3];
	logic [SqW-1:0]  fsq_q  [3];
	logic [DimW-1:0] fw_q, fh_q;

	// shared unit registers
	seq_state_t      state_q, state_d;
	logic [1:0]      ch_q;
	logic [5:0]      step_q;
	logic [NW-1:0]   n_q;
	logic [NumW-1:0] acc_q;   // numerator / product / radicand
	logic [NumW-1:0] rem_q;   // divide remainder
	logic [NumW-1:0] tmp_q;   // N*sumsq kept while sum^2 forms
	logic [DivW-1:0] dvs_q;   // divisor
	logic [31:0]     sroot_q, sbit_q;
	logic            vsat_q;  // variance quotient known to overflow 32 bits

	// output register
	logic [MeanW-1:0] omean_q [3];
	logic [DevW-1:0]  odev_q  [3];
	logic [PixW-1:0]  omin_q  [3];
	logic [PixW-1:0]  omax_q  [3];
	logic             ovld_q;

	assign pix[0] = red;
	assign pix[1] = green;
	assign pix[2] = blue;

	// clamp the dimensions
	always_comb begin
		w_eff = (width_q == '0) ? DimW'(1) :
			(width_q > DimW'(MaxWidth)) ? DimW'(MaxWidth) : width_q;
		h_eff = (height_q == '0) ? DimW'(1) :
			(height_q > DimW'(MaxHeight)) ? DimW'(MaxHeight) : height_q;
		n_full = NW'(w_eff) * NW'(h_eff);
	end

	assign cfg_ready = 1'b1;
	assign in_ready  = (state_q == ST_IDLE) && !ovld_q;
	assign in_acc    = in_valid && in_ready;
	assign last_pix  = (NW'(cnt_q) + NW'(1)) >= n_full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= DimW'(1920);
			height_q <= DimW'(1080);
		end else if (cfg_valid) begin
			case (cfg_index)
				RegWidth:  width_q  <= cfg_data;
				RegHeight: height_q <= cfg_data;
				default:   ;
			endcase
		end
	end

	// pixel accumulation; a frame's last pixel moves totals to the snapshot
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			for (int c = 0; c < 3; c++) begin
				sum_q[c] <= '0;
				sq_q[c]  <= '0;
				min_q[c] <= '1;
				max_q[c] <= '0;
			end
		end else if (in_acc) begin
			if (last_pix) begin
				cnt_q <= '0;
				for (int c = 0; c < 3; c++) begin
					sum_q[c] <= '0;
					sq_q[c]  <= '0;
					min_q[c] <= '1;
					max_q[c] <= '0;
				end
			end else begin
				cnt_q <= cnt_q + CntW'(1);
				for (int c = 0; c < 3; c++) begin
					sum_q[c] <= sum_q[c] + SumW'(pix[c]);
					sq_q[c]  <= sq_q[c] + SqW'(pix[c]) * SqW'(pix[c]);
					if (pix[c] < min_q[c]) min_q[c] <= pix[c];
					if (pix[c] > max_q[c]) max_q[c] <= pix[c];
				end
			end
		end
	end

	// snapshot and min/max result on the frame's last pixel
	always_ff @(posedge clk) begin
		if (in_acc && last_pix) begin
			fw_q <= w_eff;
			fh_q <= h_eff;
			for (int c = 0; c < 3; c++) begin
				fsum_q[c] <= sum_q[c] + SumW'(pix[c]);
				fsq_q[c]  <= sq_q[c] + SqW'(pix[c]) * SqW'(pix[c]);
				omin_q[c] <= (pix[c] < min_q[c]) ? pix[c] : min_q[c];
				omax_q[c] <= (pix[c] > max_q[c]) ? pix[c] : max_q[c];
			end
		end
	end

	// step counters finish
	logic div_done, sqrt_done;
	assign div_done  = (step_q == 6'(DivSteps - 1));
	assign sqrt_done = (sbit_q == 32'd0) || (step_q == 6'd15);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: if (in_acc && last_pix) state_d = ST_NMUL;
			ST_NMUL: state_d = ST_CHAN;
			ST_CHAN: state_d = ST_MEAN;
			ST_MEAN: if (div_done) state_d = ST_SQA;
			ST_SQA:  state_d = ST_SQH;
			ST_SQH:  state_d = ST_SQB;
			ST_SQB:  state_d = ST_DIFF;
			ST_DIFF: state_d = ST_VDIV;
			ST_VDIV: if (div_done) state_d = ST_SQRT;
			ST_SQRT: if (sqrt_done) state_d = ST_NEXT;
			ST_NEXT: state_d = (ch_q == 2'd2) ? ST_OUT : ST_CHAN;
			ST_OUT:  state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	// shared restoring divide step: rem:acc shifted left one bit
	logic [NumW-1:0] rem_sh;
	logic [NumW:0]   rem_sub;
	logic            fit;
	always_comb begin
		rem_sh  = {rem_q[NumW-2:0], acc_q[NumW-1]};
		rem_sub = {1'b0, rem_sh} - (NumW+1)'(dvs_q);
		fit     = !rem_sub[NumW];
	end

	// variance numerator N*sumsq - sum^2, clipped at zero
	logic [NumW-1:0] var_d;
	logic            var_pos;
	always_comb begin
		var_pos = tmp_q > acc_q;
		var_d   = tmp_q - acc_q;
	end

	// square root trial
	logic [32:0] sq_trial;
	logic        sq_fit;
	always_comb begin
		sq_trial = {1'b0, sroot_q} + {1'b0, sbit_q};
		sq_fit   = acc_q[31:0] >= sq_trial[31:0];
	end

	// sequencer registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			ovld_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_OUT) ovld_q <= 1'b1;
			else if (out_ready) ovld_q <= 1'b0;
		end
	end

	// shared datapath
	always_ff @(posedge clk) begin
		case (state_q)
			ST_NMUL: begin
				n_q  <= NW'(fw_q) * NW'(fh_q);
				ch_q <= 2'd0;
			end
			ST_CHAN: begin
				acc_q  <= NumW'(fsum_q[ch_q]) << (NumW - DivW + 8);
				rem_q  <= '0;
				dvs_q  <= DivW'(n_q);
				step_q <= '0;
			end
			ST_MEAN: begin
				// numerator sum<<8 fills the top DivW bits of acc
				step_q <= step_q + 6'd1;
				rem_q  <= fit ? rem_sub[NumW-1:0] : rem_sh;
				acc_q  <= {acc_q[NumW-2:0], fit};
				if (div_done)
					omean_q[ch_q] <= (|acc_q[DivW-2:MeanW-1]) ? '1 :
						{acc_q[MeanW-2:0], fit};
			end
			ST_SQA: begin
				// N*sumsq in two halves, low half first
				tmp_q <= NumW'(n_q) * NumW'(fsq_q[ch_q][SqW/2-1:0]);
				dvs_q <= DivW'(n_q) * DivW'(n_q);
			end
			ST_SQH: tmp_q <= tmp_q +
				((NumW'(n_q) * NumW'(fsq_q[ch_q][SqW-1:SqW/2])) << (SqW/2));
			ST_SQB: acc_q <= NumW'(fsum_q[ch_q]) * NumW'(fsum_q[ch_q]);
			ST_DIFF: begin
				// dividend d<<16: d>>34 preloads the remainder, d[33:0] shifts in
				acc_q  <= var_pos ? (var_d << 32) : '0;
				rem_q  <= var_pos ? (var_d >> 34) : '0;
				vsat_q <= var_pos && (var_d >= (NumW'(dvs_q) << 16));
				step_q <= '0;
			end
			ST_VDIV: begin
				step_q <= step_q + 6'd1;
				rem_q  <= fit ? rem_sub[NumW-1:0] : rem_sh;
				acc_q  <= {acc_q[NumW-2:0], fit};
				if (div_done) begin
					// low 50 bits now hold the quotient's tail; saturate to 32
					if (vsat_q || (|acc_q[DivW-2:31])) acc_q <= NumW'(32'hFFFF_FFFF);
					else acc_q <= NumW'({acc_q[30:0], fit});
					sroot_q <= '0;
					sbit_q  <= 32'h4000_0000;
					step_q  <= '0;
				end
			end
			ST_SQRT: begin
				step_q <= step_q + 6'd1;
				sbit_q <= sbit_q >> 2;
				if (sq_fit) begin
					acc_q   <= NumW'(acc_q[31:0] - sq_trial[31:0]);
					sroot_q <= (sroot_q >> 1) + sbit_q;
				end else begin
					sroot_q <= sroot_q >> 1;
				end
			end
			ST_NEXT: begin
				odev_q[ch_q] <= (|sroot_q[31:DevW]) ? '1 : sroot_q[DevW-1:0];
				ch_q <= ch_q + 2'd1;
			end
			default: ;
		endcase
	end

	assign out_valid  = ovld_q;
	assign mean_red   = omean_q[0];
	assign mean_green = omean_q[1];
	assign mean_blue  = omean_q[2];
	assign dev_red    = odev_q[0];
	assign dev_green  = odev_q[1];
	assign dev_blue   = odev_q[2];
	assign min_red    = omin_q[0];
	assign min_green  = omin_q[1];
	assign min_blue   = omin_q[2];
	assign max_red    = omax_q[0];
	assign max_green  = omax_q[1];
	assign max_blue   = omax_q[2];

endmodule

// ----- rtl/rcs_checker.sv -----
// Port-level checker for rgb_channel_statistics, bound to the top level.
// Depends on rcs_pkg for field widths.
module rcs_checker (
	input logic                      clk,
	input logic                      arst_n,
	input logic                      in_valid,
	input logic                      in_ready,
	input logic                      out_valid,
	input logic                      out_ready,
	input logic [rcs_pkg::PixW-1:0]  min_red,
	input logic [rcs_pkg::PixW-1:0]  max_red,
	input logic [rcs_pkg::MeanW-1:0] mean_red
);
	import rcs_pkg::*;

	// no pixel taken while a result waits
	a_block: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !in_ready) else $error("pixel accepted with result pending");

	// result holds while stalled
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(mean_red))
		else $error("result dropped under stall");

	// min never above max in a result
	a_order: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> min_red <= max_red) else $error("min above max");

endmodule

bind rgb_channel_statistics rcs_checker u_rcs_checker (
	.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
	.out_valid(out_valid), .out_ready(out_ready), .min_red(min_red),
	.max_red(max_red), .mean_red(mean_red)
);

// ----- sim/rgb_channel_statistics_tb.sv -----
// Self-checking testbench for rgb_channel_statistics: streams RGB frames of varied
// size, predicts per-channel mean/deviation/min/max, checks each result transaction.
// Depends on rcs_pkg and the rgb_channel_statistics RTL.
`timescale 1ns / 100ps

module rgb_channel_statistics_tb;
	import rcs_pkg::*;

	localparam int HoldOff    = 400;
	localparam int StallLimit = 20000;

	typedef struct {
		logic [PixW-1:0] r;
		logic [PixW-1:0] g;
		logic [PixW-1:0] b;
	} pixel_t;

	typedef struct {
		logic [MeanW-1:0] mean[3];
		logic [DevW-1:0]  dev[3];
		logic [PixW-1:0]  lo[3];
		logic [PixW-1:0]  hi[3];
	} frame_stats_t;

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             cfg_valid = 1'b0;
	logic             cfg_ready;
	logic [0:0]       cfg_index = RegWidth;
	logic [DimW-1:0]  cfg_data = '0;
	logic             in_valid = 1'b0;
	logic             in_ready;
	logic [PixW-1:0]  red = '0, green = '0, blue = '0;
	logic             out_valid;
	logic             out_ready = 1'b0;
	logic [MeanW-1:0] mean_red, mean_green, mean_blue;
	logic [DevW-1:0]  dev_red, dev_green, dev_blue;
	logic [PixW-1:0]  min_red, min_green, min_blue;
	logic [PixW-1:0]  max_red, max_green, max_blue;

	pixel_t       pending_pixels[$];
	frame_stats_t expected_stats[$];
	int           errors = 0;
	int           send_idle_pct = 0;
	int           recv_idle_pct = 0;
	int           quiet_cycles = 0;
	bit           px_taken = 1'b0;

	// predictor state
	longint unsigned chan_sum[3];
	longint unsigned chan_sq[3];
	logic [PixW-1:0] chan_lo[3];
	logic [PixW-1:0] chan_hi[3];
	longint unsigned pix_count;
	logic [DimW-1:0] width_reg = 13'd1920;
	logic [DimW-1:0] height_reg = 13'd1080;

	rgb_channel_statistics u_dut (.*);

	// clock, 20 ns period
	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	function automatic longint unsigned eff_dim(logic [DimW-1:0] v);
		if (v == 0) return 1;
		if (v > 4096) return 4096;
		return v;
	endfunction

	function automatic logic [31:0] root32(logic [31:0] v);
		logic [31:0] res, probe;
		res = 0;
		probe = 32'h4000_0000;
		while (probe > v) probe = probe >> 2;
		while (probe != 0) begin
			if (v >= res + probe) begin
				v = v - (res + probe);
				res = (res >> 1) + probe;
			end else begin
				res = res >> 1;
			end
			probe = probe >> 2;
		end
		return res;
	endfunction

	function automatic logic [DevW-1:0] dev_q88(longint unsigned s, longint unsigned sq,
			longint unsigned n);
		longint unsigned a, b, n2, d, q, r, vq;
		logic [31:0] root;
		a = n * sq;
		b = s * s;
		n2 = n * n;
		if (a <= b) return '0;
		d = a - b;
		q = d / n2;
		r = d % n2;
		if (q >= 65536) vq = 64'hFFFF_FFFF;
		else begin
			vq = (q << 16) + ((r << 16) / n2);
			if (vq > 64'hFFFF_FFFF) vq = 64'hFFFF_FFFF;
		end
		root = root32(vq[31:0]);
		return (root > 32'h7FFF) ? 15'h7FFF : root[DevW-1:0];
	endfunction

	function automatic void clear_frame();
		for (int c = 0; c < 3; c++) begin
			chan_sum[c] = 0;
			chan_sq[c] = 0;
			chan_lo[c] = 8'hFF;
			chan_hi[c] = 8'h00;
		end
		pix_count = 0;
	endfunction

	// accumulate one pixel; on the frame's last pixel queue the expected statistics
	function automatic void accumulate_pixel(pixel_t p);
		logic [PixW-1:0] v[3];
		longint unsigned n, m;
		frame_stats_t st;
		v = '{p.r, p.g, p.b};
		for (int c = 0; c < 3; c++) begin
			chan_sum[c] = (chan_sum[c] + v[c]) & 64'hFFFF_FFFF;
			chan_sq[c] = (chan_sq[c] + longint'(v[c]) * v[c]) & 64'hFF_FFFF_FFFF;
			if (v[c] < chan_lo[c]) chan_lo[c] = v[c];
			if (v[c] > chan_hi[c]) chan_hi[c] = v[c];
		end
		n = eff_dim(width_reg) * eff_dim(height_reg);
		if (pix_count + 1 < n) begin
			pix_count = (pix_count + 1) & 64'hFF_FFFF;
			return;
		end
		for (int c = 0; c < 3; c++) begin
			m = (chan_sum[c] << 8) / n;
			st.mean[c] = (m > 64'hFFFF) ? 16'hFFFF : m[MeanW-1:0];
			st.dev[c] = dev_q88(chan_sum[c], chan_sq[c], n);
			st.lo[c] = chan_lo[c];
			st.hi[c] = chan_hi[c];
		end
		expected_stats.push_back(st);
		clear_frame();
	endfunction

	initial clear_frame();

	// pixel driver and receiver backpressure
	always @(negedge clk) begin : drive_pixels
		pixel_t p;
		if (arst_n) begin
			if (!in_valid || px_taken) begin
				if (pending_pixels.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
					p = pending_pixels.pop_front();
					in_valid <= 1'b1;
					red <= p.r;
					green <= p.g;
					blue <= p.b;
				end else begin
					in_valid <= 1'b0;
				end
			end
			out_ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	// monitor: predict on pixel accept, check on result accept, watchdog
	always @(posedge clk) begin : watch_ports
		frame_stats_t st;
		logic [MeanW-1:0] got_mean[3];
		logic [DevW-1:0]  got_dev[3];
		logic [PixW-1:0]  got_lo[3], got_hi[3];
		string chan[3];
		if (arst_n) begin
			chan = '{"red", "green", "blue"};
			px_taken <= in_valid && in_ready;
			if (in_valid && in_ready)
				accumulate_pixel('{red, green, blue});
			if (out_valid && out_ready) begin
				got_mean = '{mean_red, mean_green, mean_blue};
				got_dev = '{dev_red, dev_green, dev_blue};
				got_lo = '{min_red, min_green, min_blue};
				got_hi = '{max_red, max_green, max_blue};
				if (expected_stats.size() == 0) begin
					$error("result transaction with no frame pending");
					errors++;
				end else begin
					st = expected_stats.pop_front();
					for (int c = 0; c < 3; c++) begin
						if (got_mean[c] !== st.mean[c]) begin
							$error("mean_%s: expected %0d, got %0d", chan[c], st.mean[c],
								got_mean[c]);
							errors++;
						end
						if (got_dev[c] !== st.dev[c]) begin
							$error("dev_%s: expected %0d, got %0d", chan[c], st.dev[c],
								got_dev[c]);
							errors++;
						end
						if (got_lo[c] !== st.lo[c]) begin
							$error("min_%s: expected %0d, got %0d", chan[c], st.lo[c],
								got_lo[c]);
							errors++;
						end
						if (got_hi[c] !== st.hi[c]) begin
							$error("max_%s: expected %0d, got %0d", chan[c], st.hi[c],
								got_hi[c]);
							errors++;
						end
					end
				end
			end
			// watchdog on cycles without any transaction
			if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
				quiet_cycles <= 0;
			else if (quiet_cycles + 1 >= StallLimit) begin
				$display("FAIL");
				$finish;
			end else
				quiet_cycles <= quiet_cycles + 1;
		end
	end

	task automatic write_reg(logic [0:0] idx, logic [DimW-1:0] val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		if (idx == RegWidth) width_reg = val;
		else height_reg = val;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// wait until every pixel is taken and every result checked, then let the
	// end-of-frame sequence drain
	task automatic wait_drained();
		do begin
			@(negedge clk);
			#1;
		end while (pending_pixels.size() > 0 || in_valid || expected_stats.size() > 0);
		repeat (HoldOff) @(posedge clk);
	endtask

	task automatic push_px(logic [7:0] r, logic [7:0] g, logic [7:0] b);
		pixel_t p;
		p = '{r, g, b};
		pending_pixels.push_back(p);
	endtask

	function automatic logic [7:0] pick_byte(int style, logic [7:0] base);
		case (style)
			0: return 8'($urandom_range(255));
			1: return $urandom_range(1) ? 8'hFF : 8'h00;
			2: return base;
			default: return base ^ 8'($urandom_range(3));
		endcase
	endfunction

	initial begin : stimulus
		int sent, frames, extra, style;
		longint unsigned n;
		logic [DimW-1:0] w, h;
		logic [7:0] base;

		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed: single-pixel frames with extreme and alternating bits
		write_reg(RegWidth, 13'd1);
		write_reg(RegHeight, 13'd1);
		push_px(8'h00, 8'h00, 8'h00);
		push_px(8'hFF, 8'hFF, 8'hFF);
		push_px(8'h55, 8'hAA, 8'h0F);
		push_px(8'hAA, 8'h55, 8'hF0);
		wait_drained();
		// 2x2 frame at maximum spread
		write_reg(RegWidth, 13'd2);
		write_reg(RegHeight, 13'd2);
		push_px(8'h00, 8'hFF, 8'h00);
		push_px(8'hFF, 8'h00, 8'hFF);
		push_px(8'h00, 8'hFF, 8'h00);
		push_px(8'hFF, 8'h00, 8'hFF);
		wait_drained();
		// solid frame: zero deviation
		write_reg(RegWidth, 13'd3);
		write_reg(RegHeight, 13'd1);
		repeat (3) push_px(8'd7, 8'd7, 8'd7);
		wait_drained();
		// shrink N mid-frame: more pixels than N, mean saturates
		write_reg(RegWidth, 13'd4);
		write_reg(RegHeight, 13'd4);
		repeat (5) push_px(8'hFF, 8'hFF, 8'h80);
		wait_drained();
		write_reg(RegWidth, 13'd1);
		write_reg(RegHeight, 13'd1);
		push_px(8'hFF, 8'h00, 8'h80);
		wait_drained();
		// grow then shrink N with a partial frame carried across
		write_reg(RegWidth, 13'd5);
		write_reg(RegHeight, 13'd5);
		repeat (3) push_px(8'($urandom_range(255)), 8'($urandom_range(255)),
			8'($urandom_range(255)));
		wait_drained();
		write_reg(RegWidth, 13'd2);
		write_reg(RegHeight, 13'd3);
		repeat (3) push_px(8'($urandom_range(255)), 8'($urandom_range(255)),
			8'($urandom_range(255)));
		wait_drained();

		// random frames of small size, in three idling regimes
		sent = 0;
		while (sent < 700) begin
			if (sent < 233) begin
				send_idle_pct = 16;
				recv_idle_pct = 65;
			end else if (sent < 466) begin
				send_idle_pct = 65;
				recv_idle_pct = 16;
			end else begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
			wait_drained();
			w = DimW'($urandom_range(6));
			h = DimW'($urandom_range(6));
			if ($urandom_range(3) != 0) write_reg(RegWidth, w);
			if ($urandom_range(3) != 0) write_reg(RegHeight, h);
			n = eff_dim(width_reg) * eff_dim(height_reg);
			frames = $urandom_range(1, 4);
			extra = ($urandom_range(3) == 0 && n > 1) ? $urandom_range(1, int'(n - 1)) : 0;
			style = $urandom_range(3);
			base = 8'($urandom_range(255));
			for (int i = 0; i < frames * n + extra; i++)
				push_px(pick_byte(style, base), pick_byte(style, base ^ 8'h3C),
					pick_byte(style, ~base));
			sent += int'(frames * n + extra);
		end

		// register extremes: all-ones width clamps to 4096 and zero height reads
		// as 1, so a few pixels leave the frame open; zero width then closes it
		wait_drained();
		write_reg(RegWidth, 13'h1FFF);
		write_reg(RegHeight, 13'd0);
		repeat (8) push_px(8'($urandom_range(255)), 8'($urandom_range(200, 255)),
			8'($urandom_range(50)));
		wait_drained();
		write_reg(RegWidth, 13'd0);
		write_reg(RegHeight, 13'd2);
		push_px(8'($urandom_range(255)), 8'($urandom_range(200, 255)),
			8'($urandom_range(50)));

		wait_drained();
		if (errors == 0) $display("PASS");
		else $display("FAIL");
		$finish;
	end

endmodule
